### rtl/core/periodic_sample_logger_dump_unit_defines.svh
// Assertion macros for the periodic sample logger dump unit.
// Used by the top level; the clock clk_i and reset rst_ni must be in scope.
`ifndef PERIODIC_SAMPLE_LOGGER_DUMP_UNIT_DEFINES_SVH
`define PERIODIC_SAMPLE_LOGGER_DUMP_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSLD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psld assertion failed");

// Next-cycle implication, checked outside reset.
`define PSLD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psld assertion failed");

`endif

### rtl/core/psld_pkg.sv
// Shared types, constants and character functions for the sample logger dump unit.
// Has no dependencies; used by psld_log_ram and periodic_sample_logger_dump_unit.
package psld_pkg;

  localparam int unsigned LOG_DEPTH      = 256;
  localparam int unsigned LOG_AW         = $clog2(LOG_DEPTH);
  localparam int unsigned TICK_W         = 18;
  localparam int unsigned TICKS_PER_UNIT = 1000;

  typedef logic [7:0]        byte_t;
  typedef logic [LOG_AW-1:0] addr_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [2:0]        cpos_t;

  localparam tick_t TICK_MAX = '1;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_DUMP = 2'd1,
    OP_SLOT = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  localparam cpos_t CP_TENS      = 3'd3;
  localparam cpos_t CP_ONES      = 3'd4;
  localparam cpos_t CP_BODY_LAST = 3'd6;
  localparam cpos_t CP_TAIL_LAST = 3'd4;

  localparam byte_t CH_D    = 8'h44;
  localparam byte_t CH_A    = 8'h41;
  localparam byte_t CH_T    = 8'h54;
  localparam byte_t CH_F    = 8'h46;
  localparam byte_t CH_I    = 8'h49;
  localparam byte_t CH_N    = 8'h4E;
  localparam byte_t CH_CR   = 8'h0D;
  localparam byte_t CH_LF   = 8'h0A;
  localparam byte_t CH_ZERO = 8'h30;

  typedef struct packed {
    logic [1:0] operation;
    byte_t      temperature;
  } in_t;

  typedef struct packed {
    byte_t tx_byte;
    logic  dump_done;
  } out_t;

  function automatic byte_t body_char(cpos_t cp);
    byte_t ch;
    case (cp)
      3'd0:    ch = CH_D;
      3'd1:    ch = CH_A;
      3'd2:    ch = CH_T;
      3'd5:    ch = CH_CR;
      default: ch = CH_LF;
    endcase
    return ch;
  endfunction

  function automatic byte_t tail_char(cpos_t cp);
    byte_t ch;
    case (cp)
      3'd0:    ch = CH_F;
      3'd1:    ch = CH_I;
      3'd2:    ch = CH_N;
      3'd3:    ch = CH_CR;
      default: ch = CH_LF;
    endcase
    return ch;
  endfunction

  // Division by ten through the reciprocal 205/2048, exact for all byte values.
  function automatic byte_t digit_char(byte_t v, logic ones);
    logic [15:0] prod;
    byte_t       quot;
    byte_t       rem;
    prod = 16'(v) * 16'd205;
    quot = byte_t'(prod[15:11]);
    rem  = v - byte_t'(quot * 8'd10);
    return ones ? byte_t'(CH_ZERO + rem) : byte_t'(CH_ZERO + quot);
  endfunction

endpackage

### rtl/core/psld_log_ram.sv
// Log store: one write port and one read port with registered read data.
// Depends on psld_pkg for the address and data types.
module psld_log_ram (
  input  logic            clk_i,
  input  logic            we_i,
  input  psld_pkg::addr_t waddr_i,
  input  psld_pkg::byte_t wdata_i,
  input  psld_pkg::addr_t raddr_i,
  output psld_pkg::byte_t rdata_o
);

  psld_pkg::byte_t mem [psld_pkg::LOG_DEPTH];
  psld_pkg::byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/periodic_sample_logger_dump_unit.sv
// Periodic sample logger with an ASCII dump: control, tick counter and output register.
// Depends on psld_pkg, psld_log_ram and periodic_sample_logger_dump_unit_defines.svh.
//
// Usage: each input beat carries an operation (tick, dump request or free transmit
// slot) and a temperature byte. Ticks store a sample once the tick count exceeds 1000
// times the period register, which the user must write through the cfg channel only
// while the block is idle; the block does not enforce this. A dump request starts a
// dump; each transmit slot during a dump yields one output beat with one character,
// and dump_done marks the final LF. A fixed-text character is registered in the output
// register and valid in the cycle after its slot beat is accepted; a digit passes the
// read state, where the log memory read data is registered, then the output register.
// Throughput is one beat per cycle unless the receiver stalls or a digit slot holds
// off the input in the read state. Beats that give no result are accepted one per
// cycle as long as no result waits. The output register lets a new beat be accepted
// in the cycle the pending result is taken; while the receiver stalls, the input is
// held off. Reset clears all control state and sets the period to 2; the log memory
// is not cleared and needs no clearing pass, since only written entries are read.
`include "periodic_sample_logger_dump_unit_defines.svh"

module periodic_sample_logger_dump_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  psld_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output psld_pkg::out_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  psld_pkg::byte_t cfg_data_i
);

  psld_pkg::state_e state_q, state_d;
  psld_pkg::byte_t  period_q;
  psld_pkg::tick_t  tick_q, tick_d, tick_inc, limit;
  psld_pkg::addr_t  entry_q, entry_d;
  psld_pkg::addr_t  rp_q, rp_d;
  psld_pkg::cpos_t  cp_q, cp_d;
  logic             dumping_q, dumping_d;
  logic             pending_q, pending_d;
  logic             trailer_q, trailer_d;
  logic             sel_ones_q, sel_ones_d;
  logic             out_valid_q, out_valid_d;
  psld_pkg::out_t   out_data_q, out_data_d, out_next;
  logic             load;
  logic             ram_we;
  psld_pkg::byte_t  ram_rdata;
  logic             in_acc;
  logic             trail_now;

  assign in_ready_o  = (state_q == psld_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign limit     = psld_pkg::tick_t'(psld_pkg::TICKS_PER_UNIT) * psld_pkg::tick_t'(period_q);
  assign tick_inc  = (tick_q == psld_pkg::TICK_MAX) ? tick_q : tick_q + 1'b1;
  assign trail_now = trailer_q || ((cp_q == '0) && (rp_q >= entry_q));

  psld_log_ram u_log_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_q),
    .wdata_i (in_data_i.temperature),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    tick_d     = tick_q;
    entry_d    = entry_q;
    rp_d       = rp_q;
    cp_d       = cp_q;
    dumping_d  = dumping_q;
    pending_d  = pending_q;
    trailer_d  = trailer_q;
    sel_ones_d = sel_ones_q;
    ram_we     = 1'b0;
    load       = 1'b0;
    out_next   = out_data_q;
    if (state_q == psld_pkg::ST_READ) begin
      load               = 1'b1;
      out_next.tx_byte   = psld_pkg::digit_char(ram_rdata, sel_ones_q);
      out_next.dump_done = 1'b0;
      state_d            = psld_pkg::ST_IDLE;
    end else if (in_acc) begin
      case (in_data_i.operation)
        psld_pkg::OP_TICK: begin
          if (!dumping_q) begin
            if (tick_inc > limit) begin
              ram_we  = 1'b1;
              entry_d = entry_q + 1'b1;
              tick_d  = '0;
            end else begin
              tick_d = tick_inc;
            end
          end
        end
        psld_pkg::OP_DUMP: begin
          if (dumping_q) begin
            pending_d = 1'b1;
          end else begin
            dumping_d = 1'b1;
            rp_d      = '0;
            cp_d      = '0;
            trailer_d = 1'b0;
          end
        end
        psld_pkg::OP_SLOT: begin
          if (dumping_q) begin
            if (trail_now) begin
              load               = 1'b1;
              out_next.tx_byte   = psld_pkg::tail_char(cp_q);
              out_next.dump_done = 1'b0;
              if (cp_q == psld_pkg::CP_TAIL_LAST) begin
                out_next.dump_done = 1'b1;
                dumping_d          = pending_q;
                pending_d          = 1'b0;
                trailer_d          = 1'b0;
                cp_d               = '0;
                rp_d               = '0;
                tick_d             = '0;
              end else begin
                trailer_d = 1'b1;
                cp_d      = cp_q + 1'b1;
              end
            end else if ((cp_q == psld_pkg::CP_TENS) || (cp_q == psld_pkg::CP_ONES)) begin
              state_d    = psld_pkg::ST_READ;
              sel_ones_d = (cp_q == psld_pkg::CP_ONES);
              cp_d       = cp_q + 1'b1;
            end else begin
              load               = 1'b1;
              out_next.tx_byte   = psld_pkg::body_char(cp_q);
              out_next.dump_done = 1'b0;
              if (cp_q == psld_pkg::CP_BODY_LAST) begin
                cp_d = '0;
                rp_d = rp_q + 1'b1;
              end else begin
                cp_d = cp_q + 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    out_valid_d = load || (out_valid_q && !out_ready_i);
    out_data_d  = load ? out_next : out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psld_pkg::ST_IDLE;
      period_q    <= 8'd2;
      tick_q      <= '0;
      entry_q     <= '0;
      rp_q        <= '0;
      cp_q        <= '0;
      dumping_q   <= 1'b0;
      pending_q   <= 1'b0;
      trailer_q   <= 1'b0;
      sel_ones_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      entry_q     <= entry_d;
      rp_q        <= rp_d;
      cp_q        <= cp_d;
      dumping_q   <= dumping_d;
      pending_q   <= pending_d;
      trailer_q   <= trailer_d;
      sel_ones_q  <= sel_ones_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        period_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  `PSLD_ASSERT_NEXT(a_read_one_cycle, state_q == psld_pkg::ST_READ, state_q == psld_pkg::ST_IDLE)
  `PSLD_ASSERT_SAME(a_read_out_free, state_q == psld_pkg::ST_READ, !out_valid_q)
  `PSLD_ASSERT_SAME(a_no_write_in_dump, ram_we, !dumping_q && state_q == psld_pkg::ST_IDLE)
  `PSLD_ASSERT_SAME(a_done_on_lf, out_valid_q && out_data_q.dump_done,
                    out_data_q.tx_byte == psld_pkg::CH_LF)

endmodule

### test/periodic_sample_logger_dump_unit_tb.sv
// Self-checking testbench for periodic_sample_logger_dump_unit: a directed table of expected
// characters, then random logging and dump rounds checked against a logger predictor in this file.
// Depends on psld_pkg and the RTL of the unit; needs no other file.
module periodic_sample_logger_dump_unit_tb;
  import psld_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         IDLE_PCT       = 18;
  localparam int         RANDOM_BEATS   = 1500;
  localparam int         STALL_LIMIT    = 2000;
  localparam int         SQUEEZE_CYCLES = 80;
  localparam int         SQUEEZE_ROUND  = 1;
  localparam int         WRAP_ROUND     = 2;
  localparam int         SLOW_ROUND     = 4;

  localparam byte_t BODY_TEXT [7] = '{CH_D, CH_A, CH_T, CH_ZERO, CH_ZERO, CH_CR, CH_LF};
  localparam byte_t TAIL_TEXT [5] = '{CH_F, CH_I, CH_N, CH_CR, CH_LF};

  typedef enum logic {
    ROW_BEAT = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] op;
    byte_t      val;
    logic       typed;
    byte_t      ch;
    logic       done;
  } plan_row_t;

  localparam logic TYPED = 1'b1;
  localparam logic PRED  = 1'b0;

  localparam plan_row_t PLAN [26] = '{
    '{ROW_BEAT, OP_UNUSED, 8'hFF, PRED,  8'h00,   1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, PRED,  8'h00,   1'b0},
    '{ROW_BEAT, OP_DUMP,   8'h00, PRED,  8'h00,   1'b0},
    '{ROW_BEAT, OP_TICK,   8'hAA, PRED,  8'h00,   1'b0},
    '{ROW_BEAT, OP_DUMP,   8'h00, PRED,  8'h00,   1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_F,    1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_I,    1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_N,    1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_CR,   1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_LF,   1'b1},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_F,    1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_I,    1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_N,    1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_CR,   1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_LF,   1'b1},
    '{ROW_CFG,  OP_TICK,   8'h00, PRED,  8'h00,   1'b0},
    '{ROW_BEAT, OP_TICK,   8'hFF, PRED,  8'h00,   1'b0},
    '{ROW_BEAT, OP_TICK,   8'h00, PRED,  8'h00,   1'b0},
    '{ROW_BEAT, OP_DUMP,   8'h00, PRED,  8'h00,   1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_D,    1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_A,    1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_T,    1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, 8'h49,   1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, 8'h35,   1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_CR,   1'b0},
    '{ROW_BEAT, OP_SLOT,   8'h00, TYPED, CH_LF,   1'b0}
  };

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_ready_o;
  in_t   in_data_i   = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  out_t  out_data_o;
  logic  cfg_valid_i = 1'b0;
  logic  cfg_ready_o;
  byte_t cfg_data_i  = '0;

  byte_t       log_mem [LOG_DEPTH];
  addr_t       n_entries;
  tick_t       ticks;
  bit          in_dump;
  bit          dump_queued;
  bit          in_tail;
  int          rd_ptr;
  int          char_pos;
  byte_t       period_setting;

  out_t        dump_chars_q [$];
  int          errors;
  int          beats_sent;
  int          useful_beats;
  int          chars_checked;
  int          dumps_done;
  int          samples_stored;
  int          periods_written;
  int unsigned cycle_no;
  int          idle_run;
  int          squeeze_cnt;
  int          squeezes_served;
  logic        steady;

  assign steady = (cycle_no >= 700) && (cycle_no < 1300);

  periodic_sample_logger_dump_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
  end

  function automatic void begin_dump();
    in_dump  = 1'b1;
    rd_ptr   = 0;
    char_pos = 0;
    in_tail  = 1'b0;
  endfunction

  function automatic bit logger_step(input in_t b, output out_t ch_out, output bit effective);
    int    limit;
    byte_t v;
    ch_out    = '0;
    effective = 1'b0;
    case (b.operation)
      OP_TICK: begin
        if (!in_dump) begin
          effective = 1'b1;
          limit = int'(TICKS_PER_UNIT) * int'(period_setting);
          if (ticks < TICK_MAX) ticks = ticks + 1'b1;
          if (int'(ticks) > limit) begin
            log_mem[n_entries] = b.temperature;
            n_entries = n_entries + 1'b1;
            ticks = '0;
            samples_stored++;
          end
        end
      end
      OP_DUMP: begin
        effective = 1'b1;
        if (in_dump) dump_queued = 1'b1;
        else begin_dump();
      end
      OP_SLOT: begin
        if (in_dump) begin
          effective = 1'b1;
          if (!in_tail && char_pos == 0 && rd_ptr >= int'(n_entries)) in_tail = 1'b1;
          if (in_tail) begin
            ch_out.tx_byte = TAIL_TEXT[char_pos];
            if (char_pos == int'(CP_TAIL_LAST)) begin
              ch_out.dump_done = 1'b1;
              in_dump  = 1'b0;
              in_tail  = 1'b0;
              char_pos = 0;
              rd_ptr   = 0;
              ticks    = '0;
              dumps_done++;
              if (dump_queued) begin
                dump_queued = 1'b0;
                begin_dump();
              end
            end else begin
              char_pos++;
            end
          end else begin
            v = log_mem[rd_ptr];
            if (char_pos == int'(CP_TENS)) ch_out.tx_byte = byte_t'(CH_ZERO + v / 8'd10);
            else if (char_pos == int'(CP_ONES)) ch_out.tx_byte = byte_t'(CH_ZERO + v % 8'd10);
            else ch_out.tx_byte = BODY_TEXT[char_pos];
            if (char_pos == int'(CP_BODY_LAST)) begin
              char_pos = 0;
              rd_ptr++;
            end else begin
              char_pos++;
            end
          end
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_beat(input logic [1:0] op, input byte_t temp,
                           input bit typed = 1'b0, input out_t want = '0);
    in_t  b;
    out_t r;
    bit   has;
    bit   eff;
    b.operation   = op;
    b.temperature = temp;
    has = logger_step(b, r, eff);
    if (has || typed) dump_chars_q.push_back(typed ? want : r);
    if (eff) useful_beats++;
    beats_sent++;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!steady && $urandom_range(99) < IDLE_PCT);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (dump_chars_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_period(input byte_t v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    period_setting = v;
    periods_written++;
  endtask

  function automatic byte_t pick_temp();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return byte_t'($urandom);
    endcase
  endfunction

  task automatic finish_dump();
    int pick;
    bit extra_req;
    extra_req = 1'b0;
    while (in_dump) begin
      pick = $urandom_range(99);
      if (pick < 4) send_beat(OP_TICK, pick_temp());
      else if (pick < 7) send_beat(OP_UNUSED, byte_t'($urandom));
      else if (pick < 8 && !extra_req) begin
        extra_req = 1'b1;
        send_beat(OP_DUMP, byte_t'($urandom));
      end else begin
        send_beat(OP_SLOT, byte_t'($urandom));
      end
    end
  endtask

  initial begin
    int    round;
    int    n_ticks;
    byte_t new_period;
    n_entries      = '0;
    ticks          = '0;
    in_dump        = 1'b0;
    dump_queued    = 1'b0;
    in_tail        = 1'b0;
    rd_ptr         = 0;
    char_pos       = 0;
    period_setting = 8'd2;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        settle();
        write_period(PLAN[i].val);
      end else begin
        send_beat(PLAN[i].op, PLAN[i].val, PLAN[i].typed, '{PLAN[i].ch, PLAN[i].done});
      end
    end

    round = 0;
    useful_beats = 0;
    while (useful_beats < RANDOM_BEATS) begin
      finish_dump();
      if (round == WRAP_ROUND || round == SLOW_ROUND) begin
        settle();
        write_period((round == SLOW_ROUND) ? 8'd1 : 8'd0);
      end else if (round == 0 || $urandom_range(3) == 0) begin
        case ($urandom_range(9))
          5:       new_period = 8'd255;
          6:       new_period = 8'd1;
          7, 8:    new_period = byte_t'($urandom_range(2, 254));
          default: new_period = 8'd0;
        endcase
        settle();
        write_period(new_period);
      end
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_beat($urandom_range(1) ? OP_SLOT : OP_UNUSED, byte_t'($urandom));
        end
      end
      if (round == SLOW_ROUND) n_ticks = 1000 + $urandom_range(0, 3);
      else if (round == WRAP_ROUND) n_ticks = 256 - int'(n_entries) + $urandom_range(0, 4);
      else if (period_setting == 8'd0) n_ticks = $urandom_range(0, 5);
      else n_ticks = $urandom_range(0, 8);
      repeat (n_ticks) send_beat(OP_TICK, pick_temp());
      if ($urandom_range(4) != 0 || round == SLOW_ROUND || round == SQUEEZE_ROUND) begin
        send_beat(OP_DUMP, byte_t'($urandom));
        if (round == SQUEEZE_ROUND) squeeze_cnt <= squeeze_cnt + 1;
      end
      round++;
    end
    finish_dump();

    in_valid_i <= 1'b0;
    while (dump_chars_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d input beats, %0d log samples stored and %0d period settings.",
             beats_sent, samples_stored, periods_written);
    $display("Checked %0d dump characters across %0d complete dumps.", chars_checked, dumps_done);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (squeeze_cnt != squeezes_served) begin
        squeezes_served++;
        out_ready_i <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dump_chars_q.size() == 0) begin
        $display("%0t: character beat with none pending, got tx_byte=%h dump_done=%b",
                 $time, out_data_o.tx_byte, out_data_o.dump_done);
        errors++;
      end else begin
        want = dump_chars_q.pop_front();
        chars_checked++;
        if (out_data_o.tx_byte !== want.tx_byte) begin
          $display("%0t: tx_byte mismatch, expected %h, actual %h",
                   $time, want.tx_byte, out_data_o.tx_byte);
          errors++;
        end
        if (out_data_o.dump_done !== want.dump_done) begin
          $display("%0t: dump_done mismatch, expected %b, actual %b",
                   $time, want.dump_done, out_data_o.dump_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run == STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles, giving up", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
